>>> src/escape_sequence_decoder_utf8_defines.svh
// assertion macros for the escape sequence decoder
// used by escape_sequence_decoder_utf8.sv, expects clk_i and rst_ni in scope
`ifndef ESCAPE_SEQUENCE_DECODER_UTF8_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_UTF8_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ESD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ESD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/esd_utf8_pkg.sv
// types, character codes and decode helpers for the escape sequence decoder
// no dependencies; used by the top level
package esd_utf8_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResIdxW    = $clog2(MaxResults);
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  // escape phase codes
  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_BSLASH = 3'd1,
    PH_OCT    = 3'd2,
    PH_HEX    = 3'd3,
    PH_U4     = 3'd4,
    PH_U8     = 3'd5
  } phase_e;

  // one decoded result slot
  typedef struct packed {
    logic [7:0] data;
    logic       bad;
  } res_t;

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D7     = 8'h37;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_UA_HEX = 8'h41;
  localparam logic [7:0] CH_UF_HEX = 8'h46;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // control codes for the simple escapes
  localparam logic [7:0] CC_BEL = 8'h07;
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_TAB = 8'h09;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_VT  = 8'h0B;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_CR  = 8'h0D;

  // digit run limits
  localparam logic [3:0] OctDigits = 4'd3;
  localparam logic [3:0] HexDigits = 4'd2;
  localparam logic [3:0] U4Digits  = 4'd4;
  localparam logic [3:0] U8Digits  = 4'd8;

  // utf-8 range limits
  localparam logic [31:0] Utf8Lim1 = 32'h0000_0080;
  localparam logic [31:0] Utf8Lim2 = 32'h0000_0800;
  localparam logic [31:0] Utf8Lim3 = 32'h0001_0000;
  localparam logic [31:0] CpMax    = 32'h0010_FFFF;

  // simple escape lookup: {hit, byte}
  function automatic logic [8:0] simple_escape(logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      CH_DQUOTE: r = {1'b1, CH_DQUOTE};
      CH_SQUOTE: r = {1'b1, CH_SQUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_LA:     r = {1'b1, CC_BEL};
      CH_LB:     r = {1'b1, CC_BS};
      CH_LF:     r = {1'b1, CC_FF};
      CH_LN:     r = {1'b1, CC_LF};
      CH_LR:     r = {1'b1, CC_CR};
      CH_LT:     r = {1'b1, CC_TAB};
      CH_LV:     r = {1'b1, CC_VT};
      default:   r = '0;
    endcase
    return r;
  endfunction

  // hex digit value: {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] t;
    logic [4:0] r;
    t = '0;
    r = '0;
    if (c >= CH_D0 && c <= CH_D9) begin
      t = c - CH_D0;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      t = c - CH_LA + 8'd10;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_UA_HEX && c <= CH_UF_HEX) begin
      t = c - CH_UA_HEX + 8'd10;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= CH_D0) && (c <= CH_D7);
  endfunction

endpackage

>>> src/esd_utf8_if.sv
// valid/ready channels for the escape sequence decoder: input and result beats
// payload widths follow the byte-wide fields of the decoder
interface esd_utf8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       literal_end;

  modport source (output valid, output in_byte, output literal_end, input ready);
  modport sink   (input valid, input in_byte, input literal_end, output ready);
endinterface

interface esd_utf8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;
  logic       bad_escape;

  modport source (output valid, output out_byte, output run_last, output string_done,
                  output bad_escape, input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_done,
                  input bad_escape, output ready);
endinterface

>>> src/escape_sequence_decoder_utf8.sv
// Escape sequence decoder, UTF-8 output. Takes one body byte of a quoted string
// literal per input beat and gives 0 to 4 result beats per input byte. An input
// beat is decoded in the cycle it is taken and its results land in a 4-slot result
// buffer. While the sink is ready, the buffer drains one beat per cycle and a byte
// yielding at most one result is taken every cycle; a byte yielding more (up to 4
// for a 4-byte UTF-8 sequence) holds the input as they drain via the single-beat-wide
// result port. A new byte is taken in the same cycle as the last pending result.
// Depends on esd_utf8_pkg, esd_utf8_if.sv and escape_sequence_decoder_utf8_defines.svh.
`include "escape_sequence_decoder_utf8_defines.svh"

module escape_sequence_decoder_utf8 (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  esd_utf8_in_if.sink           in_i,
  esd_utf8_out_if.source        out_o
);

  // decoder state
  esd_utf8_pkg::phase_e phase_q, phase_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [31:0]          acc_q, acc_d;

  // result buffer
  esd_utf8_pkg::res_t                        slot_q [esd_utf8_pkg::MaxResults];
  esd_utf8_pkg::res_t                        slot_d [esd_utf8_pkg::MaxResults];
  logic [esd_utf8_pkg::ResCntW-1:0]          rem_q, n_d;
  logic [esd_utf8_pkg::ResIdxW-1:0]          rd_q;
  logic                                      end_q;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic [4:0] hv;
  logic [8:0] esc;
  logic       run_normal;
  logic [31:0] cp;

  assign b        = in_i.in_byte;
  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  // take a new beat when the buffer is empty or its last result leaves now
  assign in_i.ready = (rem_q == '0) ||
                      ((rem_q == esd_utf8_pkg::ResCntW'(1)) && out_o.ready);

  // decode one byte into the result list and the next state
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    n_d        = '0;
    run_normal = 1'b0;
    cp         = '0;
    hv         = esd_utf8_pkg::hex_digit(b);
    esc        = esd_utf8_pkg::simple_escape(b);
    for (int i = 0; i < esd_utf8_pkg::MaxResults; i++) begin
      slot_d[i] = '0;
    end

    unique case (phase_q)
      esd_utf8_pkg::PH_BSLASH: begin
        phase_d = esd_utf8_pkg::PH_NORMAL;
        if (esc[8]) begin
          slot_d[0] = '{data: esc[7:0], bad: 1'b0};
          n_d       = esd_utf8_pkg::ResCntW'(1);
        end else if (b == esd_utf8_pkg::CH_LX) begin
          phase_d = esd_utf8_pkg::PH_HEX;
          cnt_d   = '0;
          acc_d   = '0;
        end else if (b == esd_utf8_pkg::CH_LU) begin
          phase_d = esd_utf8_pkg::PH_U4;
          cnt_d   = '0;
          acc_d   = '0;
        end else if (b == esd_utf8_pkg::CH_UU) begin
          phase_d = esd_utf8_pkg::PH_U8;
          cnt_d   = '0;
          acc_d   = '0;
        end else if (esd_utf8_pkg::is_octal(b)) begin
          phase_d = esd_utf8_pkg::PH_OCT;
          cnt_d   = 4'd1;
          acc_d   = {29'd0, b[2:0]};
        end else begin
          // unknown escape keeps the backslash
          slot_d[0] = '{data: esd_utf8_pkg::CH_BSLASH, bad: 1'b0};
          slot_d[1] = '{data: b, bad: 1'b0};
          n_d       = esd_utf8_pkg::ResCntW'(2);
        end
      end

      esd_utf8_pkg::PH_OCT: begin
        if (esd_utf8_pkg::is_octal(b)) begin
          acc_d = {acc_q[28:0], b[2:0]};
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= esd_utf8_pkg::OctDigits) begin
            slot_d[0] = '{data: acc_d[7:0], bad: 1'b0};
            n_d       = esd_utf8_pkg::ResCntW'(1);
            phase_d   = esd_utf8_pkg::PH_NORMAL;
          end
        end else begin
          slot_d[0]  = '{data: acc_q[7:0], bad: 1'b0};
          n_d        = esd_utf8_pkg::ResCntW'(1);
          phase_d    = esd_utf8_pkg::PH_NORMAL;
          run_normal = 1'b1;
        end
      end

      esd_utf8_pkg::PH_HEX: begin
        if (hv[4]) begin
          acc_d = {acc_q[27:0], hv[3:0]};
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= esd_utf8_pkg::HexDigits) begin
            slot_d[0] = '{data: acc_d[7:0], bad: 1'b0};
            n_d       = esd_utf8_pkg::ResCntW'(1);
            phase_d   = esd_utf8_pkg::PH_NORMAL;
          end
        end else begin
          if (cnt_q == '0) begin
            slot_d[0] = '{data: 8'd0, bad: 1'b1};
          end else begin
            slot_d[0] = '{data: acc_q[7:0], bad: 1'b0};
          end
          n_d        = esd_utf8_pkg::ResCntW'(1);
          phase_d    = esd_utf8_pkg::PH_NORMAL;
          run_normal = 1'b1;
        end
      end

      esd_utf8_pkg::PH_U4, esd_utf8_pkg::PH_U8: begin
        if (hv[4]) begin
          acc_d = {acc_q[27:0], hv[3:0]};
          cnt_d = cnt_q + 4'd1;
          if (cnt_d >= ((phase_q == esd_utf8_pkg::PH_U4) ? esd_utf8_pkg::U4Digits
                                                          : esd_utf8_pkg::U8Digits)) begin
            phase_d = esd_utf8_pkg::PH_NORMAL;
            cp      = acc_d;
            // utf-8 encode the finished code point
            if (cp < esd_utf8_pkg::Utf8Lim1) begin
              slot_d[0] = '{data: cp[7:0], bad: 1'b0};
              n_d       = esd_utf8_pkg::ResCntW'(1);
            end else if (cp < esd_utf8_pkg::Utf8Lim2) begin
              slot_d[0] = '{data: {3'b110, cp[10:6]}, bad: 1'b0};
              slot_d[1] = '{data: {2'b10, cp[5:0]}, bad: 1'b0};
              n_d       = esd_utf8_pkg::ResCntW'(2);
            end else if (cp < esd_utf8_pkg::Utf8Lim3) begin
              slot_d[0] = '{data: {4'b1110, cp[15:12]}, bad: 1'b0};
              slot_d[1] = '{data: {2'b10, cp[11:6]}, bad: 1'b0};
              slot_d[2] = '{data: {2'b10, cp[5:0]}, bad: 1'b0};
              n_d       = esd_utf8_pkg::ResCntW'(3);
            end else if (cp <= esd_utf8_pkg::CpMax) begin
              slot_d[0] = '{data: {5'b11110, cp[20:18]}, bad: 1'b0};
              slot_d[1] = '{data: {2'b10, cp[17:12]}, bad: 1'b0};
              slot_d[2] = '{data: {2'b10, cp[11:6]}, bad: 1'b0};
              slot_d[3] = '{data: {2'b10, cp[5:0]}, bad: 1'b0};
              n_d       = esd_utf8_pkg::ResCntW'(4);
            end else begin
              slot_d[0] = '{data: 8'd0, bad: 1'b1};
              n_d       = esd_utf8_pkg::ResCntW'(1);
            end
          end
        end else begin
          slot_d[0]  = '{data: 8'd0, bad: 1'b1};
          n_d        = esd_utf8_pkg::ResCntW'(1);
          phase_d    = esd_utf8_pkg::PH_NORMAL;
          run_normal = 1'b1;
        end
      end

      default: begin
        // normal text and the unreachable codes
        phase_d    = esd_utf8_pkg::PH_NORMAL;
        run_normal = 1'b1;
      end
    endcase

    // byte handled as normal text, after any flushed run
    if (run_normal) begin
      if (b == esd_utf8_pkg::CH_BSLASH) begin
        phase_d = esd_utf8_pkg::PH_BSLASH;
        cnt_d   = '0;
        acc_d   = '0;
      end else if (n_d != esd_utf8_pkg::ResCntW'(esd_utf8_pkg::MaxResults)) begin
        slot_d[n_d[esd_utf8_pkg::ResIdxW-1:0]] = '{data: b, bad: 1'b0};
        n_d = n_d + esd_utf8_pkg::ResCntW'(1);
      end
    end

    // end of literal closes any open escape
    if (in_i.literal_end) begin
      if (n_d != esd_utf8_pkg::ResCntW'(esd_utf8_pkg::MaxResults)) begin
        unique case (phase_d)
          esd_utf8_pkg::PH_OCT: begin
            slot_d[n_d[esd_utf8_pkg::ResIdxW-1:0]] = '{data: acc_d[7:0], bad: 1'b0};
            n_d = n_d + esd_utf8_pkg::ResCntW'(1);
          end
          esd_utf8_pkg::PH_HEX: begin
            if (cnt_d == '0) begin
              slot_d[n_d[esd_utf8_pkg::ResIdxW-1:0]] = '{data: 8'd0, bad: 1'b1};
            end else begin
              slot_d[n_d[esd_utf8_pkg::ResIdxW-1:0]] = '{data: acc_d[7:0], bad: 1'b0};
            end
            n_d = n_d + esd_utf8_pkg::ResCntW'(1);
          end
          esd_utf8_pkg::PH_BSLASH, esd_utf8_pkg::PH_U4, esd_utf8_pkg::PH_U8: begin
            slot_d[n_d[esd_utf8_pkg::ResIdxW-1:0]] = '{data: 8'd0, bad: 1'b1};
            n_d = n_d + esd_utf8_pkg::ResCntW'(1);
          end
          default: begin
          end
        endcase
      end
      phase_d = esd_utf8_pkg::PH_NORMAL;
      cnt_d   = '0;
      acc_d   = '0;
    end
  end

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= esd_utf8_pkg::PH_NORMAL;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      rd_q  <= '0;
    end else if (in_fire) begin
      rem_q <= n_d;
      rd_q  <= '0;
    end else if (out_fire) begin
      rem_q <= rem_q - esd_utf8_pkg::ResCntW'(1);
      rd_q  <= rd_q + esd_utf8_pkg::ResIdxW'(1);
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slot_q <= slot_d;
      end_q  <= in_i.literal_end;
    end
  end

  // result beat
  assign out_o.valid       = (rem_q != '0);
  assign out_o.out_byte    = slot_q[rd_q].data;
  assign out_o.bad_escape  = slot_q[rd_q].bad;
  assign out_o.run_last    = (rem_q == esd_utf8_pkg::ResCntW'(1));
  assign out_o.string_done = out_o.run_last & end_q;

  // checks
  `ESD_ASSERT_NXT(a_lit_end_clears, in_fire && in_i.literal_end,
                  phase_q == esd_utf8_pkg::PH_NORMAL && cnt_q == 4'd0,
                  "state not cleared after end of literal")
  `ESD_ASSERT_IMP(a_bad_zero, out_o.valid && out_o.bad_escape,
                  out_o.out_byte == 8'd0, "error beat carries nonzero byte")
  `ESD_ASSERT_NXT(a_drain_empty, out_fire && out_o.run_last && !in_fire,
                  !out_o.valid, "result beat after last of run")
  `ESD_ASSERT_IMP(a_rem_bound, out_o.valid,
                  rem_q <= esd_utf8_pkg::ResCntW'(esd_utf8_pkg::MaxResults),
                  "result count above buffer depth")

endmodule
